FILE: sv/tea_pkg.sv
// Shared constants, types and the round mix function for the TEA cipher pipeline.
// No dependencies.
package tea_pkg;

    localparam int unsigned ROUNDS = 32;
    localparam int unsigned STAGES = 2 * ROUNDS;
    localparam int unsigned NUM_KEYS = 4;
    localparam int unsigned ADDR_W = 4;
    localparam logic [31:0] DELTA = 32'h9E37_79B9;

    // register indexes on paddr[3:2]
    localparam logic [1:0] REG_KEY0 = 2'd0;
    localparam logic [1:0] REG_KEY1 = 2'd1;
    localparam logic [1:0] REG_KEY2 = 2'd2;
    localparam logic [1:0] REG_KEY3 = 2'd3;

    localparam logic FUNC_ENC = 1'b0;
    localparam logic FUNC_DEC = 1'b1;

    typedef logic [NUM_KEYS-1:0][31:0] t_keys;

    typedef struct packed {
        logic        func;
        logic [31:0] y;
        logic [31:0] z;
    } t_blk;

    function automatic logic [31:0] mix(
        input logic [31:0] v,
        input logic [31:0] sum,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

endpackage

FILE: sv/tea_round.sv
// One half-round stage of the TEA pipeline: updates one block word from the other.
// Depends on tea_pkg.
module tea_round (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  tea_pkg::t_blk      i_blk,
    input  tea_pkg::t_keys     i_keys,
    input  logic [31:0]        i_sum_enc,
    input  logic [31:0]        i_sum_dec,
    input  logic               i_half,
    output logic               o_vld,
    output tea_pkg::t_blk      o_blk
);

    logic          r_vld;
    tea_pkg::t_blk r_blk;
    tea_pkg::t_blk n_blk;

    logic        z_to_y;
    logic [31:0] src;
    logic [31:0] tgt;
    logic [31:0] sum;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] m;
    logic [31:0] upd;

    // encrypt: first half y from z, second half z from y; decrypt runs it the other way
    assign z_to_y = (i_half == i_blk.func);
    assign src    = z_to_y ? i_blk.z : i_blk.y;
    assign tgt    = z_to_y ? i_blk.y : i_blk.z;
    assign ka     = z_to_y ? i_keys[0] : i_keys[2];
    assign kb     = z_to_y ? i_keys[1] : i_keys[3];
    assign sum    = (i_blk.func == tea_pkg::FUNC_DEC) ? i_sum_dec : i_sum_enc;
    assign m      = tea_pkg::mix(src, sum, ka, kb);
    assign upd    = (i_blk.func == tea_pkg::FUNC_DEC) ? (tgt - m) : (tgt + m);

    always_comb begin
        n_blk      = i_blk;
        if (z_to_y) begin
            n_blk.y = upd;
        end else begin
            n_blk.z = upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
    end

    assign o_vld = r_vld;
    assign o_blk = r_blk;

endmodule

FILE: sv/tea_block_cipher_top.sv
// TEA block cipher: 64 half-round stages, one block word taken per cycle when start is high.
// Each accepted block passes one register stage per half-round before o_strobe shows it
// with the result on o_out_first and o_out_second.
// Throughput: one block per cycle; busy stays low while out of reset.
// Reset (synchronous, active low) clears the key words to zero and drops all words in flight.
// The receiver cannot stall: each result is shown on o_strobe for exactly one cycle.
// Depends on tea_pkg and tea_round.
module tea_block_cipher_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_func,
    input  logic [31:0]                i_word_first,
    input  logic [31:0]                i_word_second,
    output logic                       o_strobe,
    output logic [31:0]                o_out_first,
    output logic [31:0]                o_out_second,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tea_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    tea_pkg::t_keys r_key;
    logic           acc;
    logic           wr;
    logic [1:0]     reg_idx;

    logic          w_vld [0:tea_pkg::STAGES];
    tea_pkg::t_blk w_blk [0:tea_pkg::STAGES];

    assign busy    = ~i_rst_n;
    assign pready  = 1'b1;
    assign acc     = start && !busy;
    assign reg_idx = paddr[3:2];
    assign wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (wr) begin
            r_key[reg_idx] <= pwdata;
        end
    end

    always_comb begin
        unique case (reg_idx)
            tea_pkg::REG_KEY0: prdata = r_key[0];
            tea_pkg::REG_KEY1: prdata = r_key[1];
            tea_pkg::REG_KEY2: prdata = r_key[2];
            tea_pkg::REG_KEY3: prdata = r_key[3];
            default:           prdata = '0;
        endcase
    end

    assign w_vld[0]   = acc;
    assign w_blk[0].func = i_func;
    assign w_blk[0].y    = i_word_first;
    assign w_blk[0].z    = i_word_second;

    for (genvar j = 0; j < tea_pkg::STAGES; j++) begin : g_stage
        localparam int unsigned R = j / 2;
        // round sums are fixed per stage; only the direction picks one
        localparam logic [63:0] PE = 64'(tea_pkg::DELTA) * 64'(R + 1);
        localparam logic [63:0] PD = 64'(tea_pkg::DELTA) * 64'(tea_pkg::ROUNDS - R);

        tea_round u_round (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_vld     (w_vld[j]),
            .i_blk     (w_blk[j]),
            .i_keys    (r_key),
            .i_sum_enc (PE[31:0]),
            .i_sum_dec (PD[31:0]),
            .i_half    (1'(j % 2)),
            .o_vld     (w_vld[j+1]),
            .o_blk     (w_blk[j+1])
        );
    end

    assign o_strobe     = w_vld[tea_pkg::STAGES];
    assign o_out_first  = w_blk[tea_pkg::STAGES].y;
    assign o_out_second = w_blk[tea_pkg::STAGES].z;

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (w_vld[1] && w_blk[1].func == $past(i_func)))
        else $error("accepted word did not enter the first stage");

    a_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[tea_pkg::STAGES-1] |=> o_strobe)
        else $error("word lost in the last stage");

    a_key_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr |=> r_key[$past(reg_idx)] == $past(pwdata))
        else $error("key word write not taken");

    a_not_busy: assert property (@(posedge i_clk)
        i_rst_n |-> !busy)
        else $error("busy high out of reset");

endmodule

FILE: test/tea_block_cipher_top_tb.sv
// Self-checking testbench for tea_block_cipher_top: TEA encrypt/decrypt of 64-bit blocks.
// Blocks are predicted by an in-bench TEA model; keys are loaded and read back over APB.
// Depends on tea_pkg and the tea_block_cipher_top RTL.
module tea_block_cipher_top_tb;

    typedef struct packed {
        logic [31:0] first;
        logic [31:0] second;
    } t_word_pair;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic                       i_func = tea_pkg::FUNC_ENC;
    logic [31:0]                i_word_first = '0;
    logic [31:0]                i_word_second = '0;
    logic                       o_strobe;
    logic [31:0]                o_out_first;
    logic [31:0]                o_out_second;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [tea_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;

    logic [31:0]         key_mirror [tea_pkg::NUM_KEYS];
    t_word_pair          expected_blocks [$];

    int unsigned blocks_sent = 0;
    int unsigned blocks_checked = 0;
    int unsigned encrypt_count = 0;
    int unsigned decrypt_count = 0;
    int unsigned key_settings = 0;
    int unsigned reg_reads = 0;
    int unsigned mismatches = 0;
    int unsigned stray_words = 0;

    tea_block_cipher_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_word_first  (i_word_first),
        .i_word_second (i_word_second),
        .o_strobe      (o_strobe),
        .o_out_first   (o_out_first),
        .o_out_second  (o_out_second),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [31:0] feistel_term(
        input logic [31:0] v,
        input logic [31:0] sum,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

    function automatic t_word_pair tea_cipher_block(
        input logic        func,
        input logic [31:0] y_in,
        input logic [31:0] z_in
    );
        logic [31:0]    y;
        logic [31:0]    z;
        logic [31:0]    sum;
        t_word_pair     res;
        y = y_in;
        z = z_in;
        if (func == tea_pkg::FUNC_ENC) begin
            sum = '0;
            for (int r = 0; r < tea_pkg::ROUNDS; r++) begin
                sum = sum + tea_pkg::DELTA;
                y = y + feistel_term(z, sum, key_mirror[0], key_mirror[1]);
                z = z + feistel_term(y, sum, key_mirror[2], key_mirror[3]);
            end
        end else begin
            sum = tea_pkg::DELTA * tea_pkg::ROUNDS;
            for (int r = 0; r < tea_pkg::ROUNDS; r++) begin
                z = z - feistel_term(y, sum, key_mirror[2], key_mirror[3]);
                y = y - feistel_term(z, sum, key_mirror[0], key_mirror[1]);
                sum = sum - tea_pkg::DELTA;
            end
        end
        res.first = y;
        res.second = z;
        return res;
    endfunction

    // result checker: strobe words cannot be held off, so sample every edge
    always @(posedge i_clk) begin
        t_word_pair exp_w;
        if (i_rst_n && o_strobe) begin
            if (expected_blocks.size() == 0) begin
                stray_words++;
                if (mismatches + stray_words <= 10)
                    $display("unexpected word: %h %h", o_out_first, o_out_second);
            end else begin
                exp_w = expected_blocks.pop_front();
                blocks_checked++;
                if (o_out_first !== exp_w.first || o_out_second !== exp_w.second) begin
                    mismatches++;
                    if (mismatches + stray_words <= 10)
                        $display("word %0d mismatch: exp %h %h got %h %h", blocks_checked,
                                 exp_w.first, exp_w.second, o_out_first, o_out_second);
                end
            end
        end
    end

    // all tasks are entered and left just after a rising edge
    task automatic block_send(input logic func, input logic [31:0] y, input logic [31:0] z);
        start <= 1'b1;
        i_func <= func;
        i_word_first <= y;
        i_word_second <= z;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        expected_blocks.push_back(tea_cipher_block(func, y, z));
        blocks_sent++;
        if (func == tea_pkg::FUNC_ENC)
            encrypt_count++;
        else
            decrypt_count++;
    endtask

    task automatic idle_cycles(input int unsigned n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic int unsigned random_gap();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 65)
            return 0;
        else if (pick < 95)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    // quiet the pipe before touching the key words
    task automatic drain_pipe();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_blocks.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (!wr) begin
            reg_reads++;
            if (prdata !== key_mirror[idx]) begin
                mismatches++;
                if (mismatches + stray_words <= 10)
                    $display("key word %0d readback: exp %h got %h", idx, key_mirror[idx],
                             prdata);
            end
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // leave the bus idle between transfers
        @(posedge i_clk);
    endtask

    task automatic key_load(input logic [31:0] k0, input logic [31:0] k1,
                            input logic [31:0] k2, input logic [31:0] k3);
        logic [31:0] kv [tea_pkg::NUM_KEYS];
        logic [1:0]  regs [tea_pkg::NUM_KEYS];
        kv = '{k0, k1, k2, k3};
        regs = '{tea_pkg::REG_KEY0, tea_pkg::REG_KEY1, tea_pkg::REG_KEY2, tea_pkg::REG_KEY3};
        for (int i = 0; i < tea_pkg::NUM_KEYS; i++) begin
            apb_access(1'b1, regs[i], kv[i]);
            key_mirror[regs[i]] = kv[i];
        end
        for (int i = 0; i < tea_pkg::NUM_KEYS; i++)
            apb_access(1'b0, regs[i], '0);
        @(posedge i_clk);
        key_settings++;
    endtask

    task automatic test_reset_key();
        for (int i = 0; i < tea_pkg::NUM_KEYS; i++)
            apb_access(1'b0, i[1:0], '0);
        @(posedge i_clk);
        block_send(tea_pkg::FUNC_ENC, 32'h0000_0000, 32'h0000_0000);
        block_send(tea_pkg::FUNC_DEC, 32'h0000_0000, 32'h0000_0000);
        block_send(tea_pkg::FUNC_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        idle_cycles(3);
        block_send(tea_pkg::FUNC_DEC, 32'hFFFF_FFFF, 32'h0000_0000);
        drain_pipe();
    endtask

    task automatic test_directed_keys();
        t_word_pair ct;
        key_load(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        block_send(tea_pkg::FUNC_ENC, 32'h0000_0000, 32'h0000_0000);
        block_send(tea_pkg::FUNC_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        block_send(tea_pkg::FUNC_DEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        block_send(tea_pkg::FUNC_DEC, 32'h0000_0000, 32'h0000_0000);
        drain_pipe();
        key_load(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
        block_send(tea_pkg::FUNC_ENC, 32'hAAAA_AAAA, 32'h5555_5555);
        block_send(tea_pkg::FUNC_DEC, 32'h5555_5555, 32'hAAAA_AAAA);
        block_send(tea_pkg::FUNC_ENC, 32'h8000_0000, 32'h0000_0001);
        block_send(tea_pkg::FUNC_DEC, 32'h0000_0001, 32'h8000_0000);
        // decrypt of an encrypt must give the plaintext back
        ct = tea_cipher_block(tea_pkg::FUNC_ENC, 32'hDEAD_BEEF, 32'h0BAD_F00D);
        block_send(tea_pkg::FUNC_ENC, 32'hDEAD_BEEF, 32'h0BAD_F00D);
        block_send(tea_pkg::FUNC_DEC, ct.first, ct.second);
        drain_pipe();
        key_load(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        block_send(tea_pkg::FUNC_ENC, 32'h0123_4567, 32'h89AB_CDEF);
        block_send(tea_pkg::FUNC_DEC, 32'h0123_4567, 32'h89AB_CDEF);
        drain_pipe();
    endtask

    task automatic test_random_phase(input int unsigned n_items, input bit no_idle);
        int unsigned    sent;
        logic           f;
        logic [31:0]    y;
        logic [31:0]    z;
        t_word_pair     pair;
        sent = 0;
        while (sent < n_items) begin
            f = 1'($urandom_range(1));
            y = $urandom();
            z = $urandom();
            block_send(f, y, z);
            sent++;
            if (!no_idle)
                idle_cycles(random_gap());
            // often follow up with the inverse operation on the prediction
            if ($urandom_range(99) < 40) begin
                pair = tea_cipher_block(f, y, z);
                block_send(~f, pair.first, pair.second);
                sent++;
                if (!no_idle)
                    idle_cycles(random_gap());
            end
        end
        drain_pipe();
    endtask

    task automatic test_random_keys();
        for (int p = 0; p < 6; p++) begin
            key_load($urandom(), $urandom(), $urandom(), $urandom());
            test_random_phase(200, p == 2);
        end
        key_load(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        test_random_phase(200, 1'b0);
    endtask

    initial begin
        for (int i = 0; i < tea_pkg::NUM_KEYS; i++)
            key_mirror[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_key();
        test_directed_keys();
        test_random_keys();

        start <= 1'b0;
        @(posedge i_clk);
        while (expected_blocks.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("covered %0d blocks (%0d encrypt, %0d decrypt), %0d checked",
                 blocks_sent, encrypt_count, decrypt_count, blocks_checked);
        $display("%0d key settings, %0d key readbacks, %0d mismatches, %0d unexpected words",
                 key_settings, reg_reads, mismatches, stray_words);
        if (mismatches == 0 && stray_words == 0 && expected_blocks.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d words outstanding", expected_blocks.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
